// ----- src/bqz_pkg.sv -----
package bqz_pkg;

  // Field widths of one word on either channel
  localparam int CTRL_W  = 32;
  localparam int STEP_W  = 4;
  localparam int POINT_W = 32;
  localparam int N_CTRL  = 9;

  // Default grid resolution
  localparam int LEVEL_DEF = 10;

  typedef logic signed [CTRL_W-1:0]  ctrl_t;
  typedef logic        [STEP_W-1:0]  step_t;
  typedef logic signed [POINT_W-1:0] point_t;

  localparam point_t POINT_MAX = {1'b0, {(POINT_W-1){1'b1}}};
  localparam point_t POINT_MIN = {1'b1, {(POINT_W-1){1'b0}}};

endpackage

// ----- src/bqz_if.sv -----
interface bqz_in_if;
  import bqz_pkg::*;

  logic  valid;
  logic  ready;
  ctrl_t ctrl_00;
  ctrl_t ctrl_01;
  ctrl_t ctrl_02;
  ctrl_t ctrl_10;
  ctrl_t ctrl_11;
  ctrl_t ctrl_12;
  ctrl_t ctrl_20;
  ctrl_t ctrl_21;
  ctrl_t ctrl_22;
  step_t row_step;
  step_t col_step;

  modport source (
    output valid, ctrl_00, ctrl_01, ctrl_02, ctrl_10, ctrl_11, ctrl_12,
           ctrl_20, ctrl_21, ctrl_22, row_step, col_step,
    input  ready
  );

  modport sink (
    input  valid, ctrl_00, ctrl_01, ctrl_02, ctrl_10, ctrl_11, ctrl_12,
           ctrl_20, ctrl_21, ctrl_22, row_step, col_step,
    output ready
  );
endinterface

interface bqz_out_if;
  import bqz_pkg::*;

  logic   valid;
  logic   ready;
  point_t point_value;

  modport source (output valid, point_value, input ready);
  modport sink   (input valid, point_value, output ready);
endinterface

// ----- src/bqz_blend.sv -----
module bqz_blend #(
  parameter  int LEVEL = bqz_pkg::LEVEL_DEF,
  localparam int WGT_W = $clog2(LEVEL * LEVEL + 1),
  localparam int NUM_W = bqz_pkg::CTRL_W + 2 * WGT_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_v,
  input  bqz_pkg::ctrl_t          ctrl [bqz_pkg::N_CTRL],
  input  bqz_pkg::step_t          row_step,
  input  bqz_pkg::step_t          col_step,
  output logic                    num_v,
  output logic signed [NUM_W-1:0] num
);
  import bqz_pkg::*;

  localparam int ROW_W = CTRL_W + WGT_W;
  localparam step_t LVL = STEP_W'(LEVEL);

  typedef logic [WGT_W-1:0] wgt_t;

  logic [4:0] v_r;

  // stage 0: clamped indices to Bernstein weights
  ctrl_t ctrl_r [N_CTRL];
  wgt_t  wi_r [3];
  wgt_t  wj_r [3];
  wgt_t  wi_nxt [3];
  wgt_t  wj_nxt [3];

  // stage 1..4
  logic signed [ROW_W-1:0] prod_r [N_CTRL];
  wgt_t                    wj1_r [3];
  logic signed [ROW_W-1:0] row_r [3];
  wgt_t                    wj2_r [3];
  logic signed [NUM_W-1:0] rp_r [3];
  logic signed [NUM_W-1:0] num_r;

  function automatic void bern(input step_t step, output wgt_t w0, output wgt_t w1,
                               output wgt_t w2);
    step_t t;
    wgt_t  tw;
    wgt_t  sw;
    t  = (step > LVL) ? LVL : step;
    tw = WGT_W'(t);
    sw = WGT_W'(LVL - t);
    w0 = sw * sw;
    w1 = (sw * tw) << 1;
    w2 = tw * tw;
  endfunction

  always_comb begin
    bern(row_step, wi_nxt[0], wi_nxt[1], wi_nxt[2]);
    bern(col_step, wj_nxt[0], wj_nxt[1], wj_nxt[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctrl_r <= ctrl;
      wi_r   <= wi_nxt;
      wj_r   <= wj_nxt;
      for (int k = 0; k < N_CTRL; k++) begin
        prod_r[k] <= ROW_W'(ctrl_r[k]) * ROW_W'($signed({1'b0, wi_r[k % 3]}));
      end
      wj1_r <= wj_r;
      for (int r = 0; r < 3; r++) begin
        row_r[r] <= prod_r[3*r] + prod_r[3*r+1] + prod_r[3*r+2];
        rp_r[r]  <= NUM_W'(row_r[r]) * NUM_W'($signed({1'b0, wj2_r[r]}));
      end
      wj2_r <= wj1_r;
      num_r <= rp_r[0] + rp_r[1] + rp_r[2];
    end
  end

  assign num_v = v_r[4];
  assign num   = num_r;

endmodule

// ----- src/bqz_div.sv -----
module bqz_div #(
  parameter  int LEVEL = bqz_pkg::LEVEL_DEF,
  localparam int WGT_W = $clog2(LEVEL * LEVEL + 1),
  localparam int NUM_W = bqz_pkg::CTRL_W + 2 * WGT_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    num_v,
  input  logic signed [NUM_W-1:0] num,
  output logic                    res_v,
  output bqz_pkg::point_t         res
);
  import bqz_pkg::*;

  localparam int QW     = POINT_W;
  localparam int N2_W   = NUM_W + 1;
  localparam int NST    = 6;
  localparam int DEN_I  = LEVEL * LEVEL * LEVEL * LEVEL;
  localparam int DEN2_I = 2 * DEN_I;
  // the top QW bits of the doubled numerator feed the reciprocal multiply
  localparam int SH     = N2_W - QW;
  localparam int LOG_D  = $clog2(DEN2_I + 1) - 1;
  localparam int P      = QW - 1 + LOG_D - SH;
  // the estimate falls short by at most twelve divisors; fix up to fifteen
  localparam int CORR_N = 15;
  localparam int CORR_W = $clog2(CORR_N + 1);
  localparam int RW     = $clog2((CORR_N + 1) * DEN2_I);
  localparam logic [N2_W-1:0] DEN    = N2_W'(DEN_I);
  localparam logic [RW-1:0]   DEN2_R = RW'(DEN2_I);
  localparam logic [QW-1:0]   RCP    = QW'((64'd1 << (P + SH)) / 64'(DEN2_I));
  localparam logic [QW-1:0]   HALF   = {1'b1, {(QW-1){1'b0}}};

  logic [NST-1:0]  v_r;
  logic [NST-2:0]  neg_r;
  logic [N2_W-1:0] n_r;
  logic [QW-1:0]   qe1_r;
  logic [RW-1:0]   nlo1_r;
  logic [RW-1:0]   qd_r;
  logic [QW-1:0]   qe2_r;
  logic [RW-1:0]   nlo2_r;
  logic [RW-1:0]   rem_r;
  logic [QW-1:0]   qe3_r;
  logic [QW-1:0]   q_r;
  point_t          sat_r;

  logic [NUM_W-1:0]  mag;
  logic [2*QW-1:0]   prod;
  logic [CORR_W-1:0] corr;
  point_t            sat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], num_v};
    end
  end

  // entry: magnitude, doubled, plus the divisor for round-half-away
  always_comb begin
    mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  end

  // quotient estimate from the top bits, never above the true quotient
  always_comb begin
    prod = (2*QW)'(n_r[N2_W-1:SH]) * (2*QW)'(RCP);
  end

  // count the divisors still left in the remainder
  always_comb begin
    corr = '0;
    for (int k = 1; k <= CORR_N; k++) begin
      if (rem_r >= RW'(k * DEN2_I)) corr = CORR_W'(k);
    end
  end

  // restore sign and clamp to the Q16.16 range
  always_comb begin
    if (neg_r[NST-2]) begin
      sat_nxt = (q_r > HALF) ? POINT_MIN : point_t'(-q_r);
    end else begin
      sat_nxt = (q_r > HALF - 1'b1) ? POINT_MAX : point_t'(q_r);
    end
  end

  // only the low RW bits matter once the estimate is close
  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= {mag, 1'b0} + DEN;
      neg_r  <= {neg_r[NST-3:0], num[NUM_W-1]};
      qe1_r  <= prod[P +: QW];
      nlo1_r <= n_r[RW-1:0];
      qd_r   <= qe1_r[RW-1:0] * DEN2_R;
      qe2_r  <= qe1_r;
      nlo2_r <= nlo1_r;
      rem_r  <= nlo2_r - qd_r;
      qe3_r  <= qe2_r;
      q_r    <= qe3_r + QW'(corr);
      sat_r  <= sat_nxt;
    end
  end

  assign res_v = v_r[NST-1];
  assign res   = sat_r;

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("divider valid bits moved during a stall");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> v_r[1] == $past(v_r[0]))
    else $error("divider valid bit lost on advance");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> rem_r < RW'(CORR_N * DEN2_I))
    else $error("divider remainder beyond the fix-up range");

endmodule

// ----- src/bqz_out_skid.sv -----
module bqz_out_skid (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pipe_v,
  input  bqz_pkg::point_t pipe_d,
  output logic            en,
  bqz_out_if.source       out_ch
);
  import bqz_pkg::*;

  logic   out_v_r;
  point_t out_d_r;
  logic   skid_v_r;
  point_t skid_d_r;
  logic   load;
  logic   push;

  assign en   = !skid_v_r;
  assign load = !out_v_r || out_ch.ready;
  assign push = pipe_v && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (load) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_d_r <= skid_v_r ? skid_d_r : pipe_d;
    end else if (push) begin
      skid_d_r <= pipe_d;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.point_value = out_d_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid filled while output could take the word");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_ch.ready |=> !skid_v_r)
    else $error("skid not drained after output handshake");

endmodule

// ----- src/biquadratic_bezier_point_eval_unit.sv -----
// Channel   Dir   Handshake       Word
// in_ch     in    valid / ready   ctrl_00..ctrl_22 (Q16.16), row_step, col_step
// out_ch    out   valid / ready   point_value (Q16.16, saturated)
//
// One word accepted per clock while in_ch.ready is high. Words pass five blend
// stages, six stages for the rounding divide by LEVEL^4 (reciprocal estimate,
// remainder fix-up, saturate) and the output register before out_ch.valid.
// Reset (rst_n low at a clock edge) clears every valid bit; data is left as is.
// A stalled output holds its word and the next one parks in a skid register;
// only when that is full does the whole pipeline freeze, so nothing is dropped.
module biquadratic_bezier_point_eval_unit #(
  parameter int LEVEL = bqz_pkg::LEVEL_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  bqz_in_if.sink    in_ch,
  bqz_out_if.source out_ch
);
  import bqz_pkg::*;

  localparam int WGT_W = $clog2(LEVEL * LEVEL + 1);
  localparam int NUM_W = CTRL_W + 2 * WGT_W;

  logic                    en;
  ctrl_t                   ctrl [N_CTRL];
  logic                    num_v;
  logic signed [NUM_W-1:0] num;
  logic                    res_v;
  point_t                  res;

  // gather the patch row-major, row r column c at index 3r+c
  assign ctrl[0] = in_ch.ctrl_00;
  assign ctrl[1] = in_ch.ctrl_01;
  assign ctrl[2] = in_ch.ctrl_02;
  assign ctrl[3] = in_ch.ctrl_10;
  assign ctrl[4] = in_ch.ctrl_11;
  assign ctrl[5] = in_ch.ctrl_12;
  assign ctrl[6] = in_ch.ctrl_20;
  assign ctrl[7] = in_ch.ctrl_21;
  assign ctrl[8] = in_ch.ctrl_22;

  // the whole pipeline advances together; hold it only while the skid is full
  assign in_ch.ready = en;

  // blend rows along i, then the row results along j; exact sum of the numerator
  bqz_blend #(.LEVEL(LEVEL)) u_blend (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_ch.valid),
    .ctrl     (ctrl),
    .row_step (in_ch.row_step),
    .col_step (in_ch.col_step),
    .num_v    (num_v),
    .num      (num)
  );

  // divide by LEVEL^4, round half away from zero, saturate
  bqz_div #(.LEVEL(LEVEL)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .num_v (num_v),
    .num   (num),
    .res_v (res_v),
    .res   (res)
  );

  // output register plus one skid word decouple ready from the pipeline
  bqz_out_skid u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .pipe_v (res_v),
    .pipe_d (res),
    .en     (en),
    .out_ch (out_ch)
  );

endmodule
